// File: design/atp_pkg.sv
// Shared types, coefficients and fixed-point helpers for the atan2 pipeline.
package atp_pkg;

  localparam int QUOT_BITS  = 16;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = QUOT_BITS / DIV_STEPS;

  localparam logic [15:0] COEF_C1 = 16'd10736;
  localparam logic [15:0] COEF_C2 = 16'd5220;
  localparam logic [15:0] COEF_C3 = 16'd1524;

  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;

  typedef struct packed {
    logic swap;
    logic xneg;
    logic yneg;
  } atp_flags_t;

  typedef struct packed {
    logic [QUOT_BITS-1:0] a;
    atp_flags_t           fl;
  } atp_ratio_t;

  typedef struct packed {
    logic [QUOT_BITS-1:0] a;
    logic [QUOT_BITS-1:0] d;
    atp_flags_t           fl;
  } atp_corr_t;

  function automatic logic [15:0] mul_q15(input logic [15:0] p, input logic [15:0] q);
    logic [31:0] prod;
    prod = 32'(p) * 32'(q) + 32'd16384;
    return prod[30:15];
  endfunction

endpackage

// File: design/atp_coord_if.sv
// Coordinate pair channel: valid, ready and signed x/y payload.
interface atp_coord_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// File: design/atp_angle_if.sv
// Angle result channel: valid, ready and signed angle payload.
interface atp_angle_if #(parameter int ANGLE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

// File: design/atp_div.sv
// Magnitude, min/max ordering and pipelined restoring divider for the Q1.15 ratio.
module atp_div import atp_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output atp_ratio_t                    out_data
);

  localparam int NS = DIV_STAGES + 1;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [COORD_WIDTH:0]   rem  [DIV_STAGES];
  logic [COORD_WIDTH-1:0] hi   [DIV_STAGES];
  logic [QUOT_BITS-1:0]   quo  [DIV_STAGES];
  atp_flags_t             fl   [NS];
  logic                   zero [NS];

  logic                   x_neg, y_neg;
  logic [COORD_WIDTH-1:0] ax, ay, lo_v, hi_v;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  assign x_neg = x_coord[COORD_WIDTH-1];
  assign y_neg = y_coord[COORD_WIDTH-1];
  assign ax    = x_neg ? ($unsigned(~x_coord) + 1'b1) : $unsigned(x_coord);
  assign ay    = y_neg ? ($unsigned(~y_coord) + 1'b1) : $unsigned(y_coord);
  assign lo_v  = (ax < ay) ? ax : ay;
  assign hi_v  = (ax < ay) ? ay : ax;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0]     <= {1'b0, lo_v};
      hi[0]      <= hi_v;
      fl[0].swap <= ay > ax;
      fl[0].xneg <= x_neg;
      fl[0].yneg <= y_neg;
      zero[0]    <= hi_v == '0;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    logic [QUOT_BITS-1:0]   quo_in;
    logic [QUOT_BITS-1:0]   quo_next;
    logic [COORD_WIDTH:0]   rem_next;

    if (j == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_rest
      assign quo_in = quo[j-1];
    end

    always_comb begin
      rem_next = rem[j];
      quo_next = quo_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        if (rem_next >= {1'b0, hi[j]}) begin
          rem_next = rem_next - {1'b0, hi[j]};
          quo_next = {quo_next[QUOT_BITS-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[QUOT_BITS-2:0], 1'b0};
        end
        rem_next = {rem_next[COORD_WIDTH-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j+1]) begin
        quo[j]    <= quo_next;
        fl[j+1]   <= fl[j];
        zero[j+1] <= zero[j];
      end
    end

    if (j < DIV_STAGES - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (rdy[j+1]) begin
          rem[j+1] <= rem_next;
          hi[j+1]  <= hi[j];
        end
      end
    end
  end

  assign out_valid   = vld[NS-1];
  assign out_data.a  = zero[NS-1] ? '0 : quo[DIV_STAGES-1];
  assign out_data.fl = fl[NS-1];

endmodule

// File: design/atp_poly.sv
// Four-stage Q15 evaluation of the odd arctangent polynomial correction term.
module atp_poly import atp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  atp_ratio_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output atp_corr_t  out_data
);

  localparam int NS = 4;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [15:0] a0, s0;
  logic [15:0] a1, s1, t1, m1;
  logic [15:0] a2, m2, t2;
  logic [15:0] a3, d3;
  atp_flags_t  fl0, fl1, fl2, fl3;
  logic [15:0] v, q;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  assign v = COEF_C2 - t1;
  assign q = COEF_C1 - t2;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a0  <= in_data.a;
      s0  <= mul_q15(in_data.a, in_data.a);
      fl0 <= in_data.fl;
    end
    if (rdy[1]) begin
      a1  <= a0;
      s1  <= s0;
      t1  <= mul_q15(COEF_C3, s0);
      m1  <= mul_q15(a0, s0);
      fl1 <= fl0;
    end
    if (rdy[2]) begin
      a2  <= a1;
      m2  <= m1;
      t2  <= mul_q15(v, s1);
      fl2 <= fl1;
    end
    if (rdy[3]) begin
      a3  <= a2;
      d3  <= mul_q15(m2, q);
      fl3 <= fl2;
    end
  end

  assign out_valid   = vld[NS-1];
  assign out_data.a  = a3;
  assign out_data.d  = d3;
  assign out_data.fl = fl3;

endmodule

// File: design/atp_quad.sv
// Octant result, quadrant reflection, rounding and sign for the output angle.
module atp_quad import atp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  atp_corr_t                           in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ANGLE_FRAC_BITS+2:0]   angle
);

  localparam int          ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
  localparam int          RND_SHIFT   = 30 - ANGLE_FRAC_BITS;
  localparam logic [32:0] RND_Q30     = 33'd1 << (29 - ANGLE_FRAC_BITS);
  localparam int          NS          = 3;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;

  logic [15:0]            r;
  logic [31:0]            zq, z1_next, z2;
  logic [32:0]            zr;
  logic [31:0]            z1;
  logic [ANGLE_WIDTH-1:0] mag, ang_q;
  atp_flags_t             fl0, fl1;

  always_comb begin
    rdy[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? in_valid : vld[k-1];
        end
      end
    end
  end

  assign r       = (in_data.d > in_data.a) ? '0 : in_data.a - in_data.d;
  assign zq      = {1'b0, r, 15'd0};
  assign z1_next = in_data.fl.swap ? HALF_PI_Q30 - zq : zq;
  assign z2      = fl0.xneg ? PI_Q30 - z1 : z1;
  assign zr      = ({1'b0, z2} + RND_Q30) >> RND_SHIFT;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      z1  <= z1_next;
      fl0 <= in_data.fl;
    end
    if (rdy[1]) begin
      mag <= zr[ANGLE_WIDTH-1:0];
      fl1 <= fl0;
    end
    if (rdy[2]) begin
      ang_q <= fl1.yneg ? '0 - mag : mag;
    end
  end

  assign out_valid = vld[NS-1];
  assign angle     = $signed(ang_q);

endmodule

// File: design/atan2_polynomial_approx_top.sv
// Top level of the pipelined four-quadrant arctangent block.
// Usage:
//   coord  (sink): one signed x/y coordinate pair per transfer, common scale.
//   result (source): atan2(y, x) in radians, signed Q3.ANGLE_FRAC_BITS,
//   from -pi to pi; zero in, zero out.
// Pipeline: an input transfer passes through 1 magnitude stage, 4 divider
//   stages of 4 quotient bits each, 4 polynomial stages with one Q15
//   multiply per path and 3 reflect/round stages before its result transfer.
// Throughput: one pair per cycle unless stalled; the pipeline depth is set by the
//   restoring divider chain and the dependent multiplies of the polynomial.
// Reset: rst is synchronous and clears every stage valid bit; no result is
//   offered in the cycle after reset.
// Stall: when result.ready is low the final stage holds its result while
//   earlier empty stages keep filling, so coord.ready drops only once every
//   stage holds an item. Nothing is dropped or repeated.
module atan2_polynomial_approx_top import atp_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input logic          clk,
  input logic          rst,
  atp_coord_if.sink    coord,
  atp_angle_if.source  result
);

  logic       div_valid, div_ready;
  atp_ratio_t div_data;
  logic       poly_valid, poly_ready;
  atp_corr_t  poly_data;

  atp_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coord.valid),
    .in_ready  (coord.ready),
    .x_coord   (coord.x_coord),
    .y_coord   (coord.y_coord),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  atp_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_data   (div_data),
    .out_valid (poly_valid),
    .out_ready (poly_ready),
    .out_data  (poly_data)
  );

  atp_quad #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_quad (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (poly_valid),
    .in_ready  (poly_ready),
    .in_data   (poly_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .angle     (result.angle)
  );

endmodule

// File: design/atp_checker.sv
// Port-level checks for the atan2 block and their bind to the top level.
module atp_checker import atp_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 13
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              coord_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [ANGLE_FRAC_BITS+2:0] angle
);

  localparam int          ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
  localparam logic [63:0] LIM64 =
    ({32'd0, PI_Q30} + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_LIM = LIM64[ANGLE_WIDTH-1:0];

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(angle))
    else $error("stalled result changed or vanished");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> coord_ready)
    else $error("input blocked while output side takes results");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (angle <= ANGLE_LIM) && (angle >= -ANGLE_LIM))
    else $error("angle outside -pi..pi");

endmodule

bind atan2_polynomial_approx_top atp_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_atp_checker (
  .clk          (clk),
  .rst          (rst),
  .coord_ready  (coord.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .angle        (result.angle)
);

// File: test/atan2_angle_check.sv
// Angle checker: watches both channels, predicts atan2 per coordinate pair and compares.
`timescale 1ns / 1ps

module atan2_angle_check import atp_pkg::*; #(
  parameter int COORD_WIDTH     = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic  clk,
  input  logic  rst,
  atp_coord_if  coord,
  atp_angle_if  result,
  output int    errors,
  output int    pending,
  output int    checked
);

  localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic        [ANGLE_WIDTH-1:0] angle;
  } angle_due_t;

  angle_due_t angles_due[$];

  function automatic longint unsigned q15_product(longint unsigned p, longint unsigned q);
    return (p * q + 64'd16384) >> 15;
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] atan2_q13(logic signed [COORD_WIDTH-1:0] x,
                                                       logic signed [COORD_WIDTH-1:0] y);
    longint sx, sy;
    longint unsigned ax, ay, lo, hi, ratio, sq, inner, outer, cube, corr, oct, z;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    lo = (ax < ay) ? ax : ay;
    hi = (ax > ay) ? ax : ay;
    ratio = (hi == 0) ? 64'd0 : (lo << 15) / hi;
    sq    = q15_product(ratio, ratio);
    inner = COEF_C2 - q15_product(COEF_C3, sq);
    outer = COEF_C1 - q15_product(inner, sq);
    cube  = q15_product(ratio, sq);
    corr  = q15_product(cube, outer);
    oct   = (corr > ratio) ? 64'd0 : ratio - corr;
    z = oct << 15;
    if (ay > ax) z = HALF_PI_Q30 - z;
    if (sx < 0) z = PI_Q30 - z;
    z = (z + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
    if (sy < 0) z = 64'd0 - z;
    return z[ANGLE_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    angle_due_t due;
    if (!rst) begin
      if (coord.valid && coord.ready) begin
        due.x     = coord.x_coord;
        due.y     = coord.y_coord;
        due.angle = atan2_q13(coord.x_coord, coord.y_coord);
        angles_due.push_back(due);
      end
      if (result.valid && result.ready) begin
        if (angles_due.size() == 0) begin
          report_mismatch($sformatf("angle %0d with no coordinate pair waiting",
                                    result.angle));
        end else begin
          due = angles_due.pop_front();
          checked++;
          if (result.angle !== due.angle)
            report_mismatch($sformatf("x=%0d y=%0d angle got %0d want %0d",
                                      due.x, due.y, result.angle,
                                      $signed(due.angle)));
        end
      end
      pending = angles_due.size();
    end
  end

endmodule

// File: test/tb.sv
// Testbench top: clock, reset, coordinate stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int RANDOM_PAIRS    = 700;
  localparam int DIRECTED_PAIRS  = 24;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int LONG_HOLD       = 120;

  typedef enum int {DRAIN_FULL, DRAIN_HALF, DRAIN_SPARSE, DRAIN_MOSTLY} drain_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   sent_count = 0;
  int   cycle_count;
  int   errors, pending, checked;

  int dir_x[DIRECTED_PAIRS] = '{0, 0, 0, 1, -1, 0, 0, 32767, -32768, 1, -1, -1,
                                1, 32767, -32768, -32768, 32767, -32767, 32767, 1,
                                -32768, -1, 300, -12345};
  int dir_y[DIRECTED_PAIRS] = '{0, 1, -1, 0, 0, 32767, -32768, 0, 0, 1, 1, -1,
                                -1, 32767, -32768, 32767, -32768, -32768, 1, 32767,
                                1, -32768, -299, 6789};

  atp_coord_if #(.COORD_WIDTH(COORD_WIDTH))       coord_ch ();
  atp_angle_if #(.ANGLE_WIDTH(ANGLE_FRAC_BITS + 3)) angle_ch ();

  atan2_polynomial_approx_top #(
    .COORD_WIDTH    (COORD_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .coord (coord_ch),
    .result(angle_ch)
  );

  atan2_angle_check #(
    .COORD_WIDTH    (COORD_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) angle_check (
    .clk    (clk),
    .rst    (rst),
    .coord  (coord_ch),
    .result (angle_ch),
    .errors (errors),
    .pending(pending),
    .checked(checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic random_pair(output logic signed [15:0] x, output logic signed [15:0] y);
    int mag;
    int extremes[6];
    extremes = '{-32768, -32767, -1, 0, 1, 32767};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      4: begin
        x = 16'($urandom_range(0, 16) - 8);
        y = 16'($urandom_range(0, 16) - 8);
      end
      5: begin
        mag = $urandom_range(0, 32768);
        x = 16'($urandom_range(0, 1) ? -mag : mag);
        y = 16'($urandom_range(0, 1) ? -mag : mag);
      end
      6: begin
        mag = 16'($urandom);
        x = $urandom_range(0, 1) ? 16'(mag) : 16'd0;
        y = (x == 0) ? 16'(mag) : 16'd0;
      end
      7: begin
        x = 16'($urandom);
        y = $urandom_range(0, 1) ? 16'(x + $urandom_range(0, 6) - 3)
                                 : 16'(-x + $urandom_range(0, 6) - 3);
      end
      8: begin
        x = 16'(extremes[$urandom_range(0, 5)]);
        y = 16'(extremes[$urandom_range(0, 5)]);
      end
      default: begin
        x = 16'($urandom);
        y = 16'($urandom_range(0, 8) - 4);
        if ($urandom_range(0, 1)) begin
          mag = x;
          x = y;
          y = 16'(mag);
        end
      end
    endcase
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d angles still outstanding", cycle_count, pending);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : drain
    drain_mode_t mode;
    int          hold;
    int          span;
    logic        held;
    angle_ch.ready <= 1'b0;
    mode = DRAIN_FULL;
    hold = 0;
    span = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 150) begin
        held = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        angle_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = drain_mode_t'($urandom_range(0, 3));
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          DRAIN_FULL:   angle_ch.ready <= 1'b1;
          DRAIN_HALF:   angle_ch.ready <= 1'($urandom_range(0, 1));
          DRAIN_SPARSE: angle_ch.ready <= ($urandom_range(0, 3) == 0);
          default:      angle_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic signed [15:0] x, y;
    int                 burst, gap;
    coord_ch.valid   <= 1'b0;
    coord_ch.x_coord <= '0;
    coord_ch.y_coord <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    burst = 0;
    for (int i = 0; i < DIRECTED_PAIRS + RANDOM_PAIRS; i++) begin
      if (i < DIRECTED_PAIRS) begin
        x = 16'(dir_x[i]);
        y = 16'(dir_y[i]);
      end else begin
        random_pair(x, y);
      end
      if (burst == 0) begin
        burst = $urandom_range(0, 3) == 0 ? $urandom_range(60, 150) : $urandom_range(1, 24);
        gap   = $urandom_range(1, 8);
        coord_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst--;
      coord_ch.valid   <= 1'b1;
      coord_ch.x_coord <= x;
      coord_ch.y_coord <= y;
      @(posedge clk);
      while (!coord_ch.ready) @(posedge clk);
      sent_count++;
    end
    coord_ch.valid <= 1'b0;
    while (checked < sent_count) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("%0d coordinate pairs sent (%0d directed), %0d angles compared in %0d cycles",
             sent_count, DIRECTED_PAIRS, checked, cycle_count);
    $display("long result stall of %0d cycles included, %0d mismatches", LONG_HOLD, errors);
    if (errors == 0 && checked == sent_count)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
